// File: hdl/mts_pkg.sv
`default_nettype none
package mts_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} mts_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_has_byte;
		logic       out_last;
	} mts_out_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_EMIT,
		ACT_HOLD,
		ACT_DISCARD
	} mts_act_t;

	// one command per accepted beat: optional flush, one action, optional final flush
	typedef struct packed {
		logic       rel_first;
		mts_act_t   act;
		logic [7:0] data;
		logic       rel_after;
		logic       last;
	} mts_cmd_t;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_G     = 8'h67;

	localparam int QDEPTH = 2;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic is_alnum(input logic [7:0] b);
		return is_letter(b) || (b >= 8'h30 && b <= 8'h39);
	endfunction

endpackage
`default_nettype wire

// File: hdl/mts_front.sv
`default_nettype none
module mts_front
	import mts_pkg::*;
#(
	parameter int MAX_NAME = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mts_in_t  item,
	input  wire logic     item_valid,
	output logic          item_ready,
	output mts_cmd_t      cmd,
	output logic          cmd_valid,
	input  wire logic     cmd_ready
);

	localparam int DEPTH = MAX_NAME + 5;
	localparam int CW    = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		M_OUT,
		M_OPEN,
		M_SLASH,
		M_NAME,
		M_PREFIXED
	} mode_t;

	mode_t         mode_q, mode_n;
	logic [1:0]    pp_q, pp_n;
	logic          slash_q, slash_n;
	logic [CW-1:0] cnt_q, cnt_n;

	logic [7:0]    b;
	logic [CW-1:0] base, name_len, hold_cnt;
	logic          prefix_g, brk, accept;

	assign item_ready = cmd_ready;
	assign cmd_valid  = item_valid;
	assign accept     = item_valid && cmd_ready;

	always_comb begin
		b        = item.in_byte;
		base     = CW'(1) + CW'(slash_q) + ((pp_q == 2'd3) ? CW'(3) : '0);
		name_len = (cnt_q > base) ? cnt_q - base : '0;
		hold_cnt = (cnt_q < CW'(DEPTH)) ? cnt_q + CW'(1) : cnt_q;
		prefix_g = (pp_q == 2'd1) && (b == CH_G);
		brk      = 1'b0;

		cmd.rel_first = 1'b0;
		cmd.act       = ACT_NONE;
		cmd.data      = b;
		cmd.rel_after = 1'b0;
		cmd.last      = item.in_last;

		mode_n  = mode_q;
		pp_n    = pp_q;
		slash_n = slash_q;
		cnt_n   = cnt_q;

		unique case (mode_q)
			M_OUT: begin
				if (b == CH_LT) begin
					cmd.act = ACT_HOLD;
					mode_n  = M_OPEN;
					cnt_n   = CW'(1);
					pp_n    = 2'd0;
					slash_n = 1'b0;
				end else begin
					cmd.act = ACT_EMIT;
				end
			end
			M_OPEN, M_SLASH: begin
				if (mode_q == M_OPEN && b == CH_SLASH) begin
					cmd.act = ACT_HOLD;
					mode_n  = M_SLASH;
					slash_n = 1'b1;
					cnt_n   = hold_cnt;
				end else if (is_letter(b)) begin
					cmd.act = ACT_HOLD;
					pp_n    = (b == CH_B) ? 2'd1 : 2'd0;
					mode_n  = M_NAME;
					cnt_n   = hold_cnt;
				end else begin
					brk = 1'b1;
				end
			end
			M_PREFIXED: begin
				if (is_letter(b)) begin
					cmd.act = ACT_HOLD;
					pp_n    = 2'd3;
					mode_n  = M_NAME;
					cnt_n   = hold_cnt;
				end else begin
					brk = 1'b1;
				end
			end
			M_NAME: begin
				if (is_alnum(b)) begin
					if (name_len >= CW'(MAX_NAME) && !prefix_g) begin
						brk = 1'b1;
					end else begin
						cmd.act = ACT_HOLD;
						cnt_n   = hold_cnt;
						if (pp_q != 2'd3)
							pp_n = prefix_g ? 2'd2 : 2'd0;
					end
				end else if (b == CH_COLON && pp_q == 2'd2) begin
					cmd.act = ACT_HOLD;
					cnt_n   = hold_cnt;
					mode_n  = M_PREFIXED;
				end else if (b == CH_GT) begin
					if (name_len > CW'(MAX_NAME)) begin
						brk = 1'b1;
					end else begin
						cmd.act = ACT_DISCARD;
						cnt_n   = '0;
						pp_n    = 2'd0;
						mode_n  = M_OUT;
					end
				end else begin
					brk = 1'b1;
				end
			end
			default: begin
				cmd.rel_first = 1'b1;
				mode_n        = M_OUT;
				cnt_n         = '0;
				pp_n          = 2'd0;
			end
		endcase

		if (brk) begin
			cmd.rel_first = 1'b1;
			pp_n          = 2'd0;
			slash_n       = 1'b0;
			if (b == CH_LT) begin
				cmd.act = ACT_HOLD;
				mode_n  = M_OPEN;
				cnt_n   = CW'(1);
			end else begin
				cmd.act = ACT_EMIT;
				mode_n  = M_OUT;
				cnt_n   = '0;
			end
		end

		// end of message flushes any open candidate
		if (item.in_last && mode_n != M_OUT) begin
			cmd.rel_after = 1'b1;
			mode_n        = M_OUT;
			cnt_n         = '0;
			pp_n          = 2'd0;
			slash_n       = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_OUT;
			pp_q    <= 2'd0;
			slash_q <= 1'b0;
			cnt_q   <= '0;
		end else if (accept) begin
			mode_q  <= mode_n;
			pp_q    <= pp_n;
			slash_q <= slash_n;
			cnt_q   <= cnt_n;
		end
	end

endmodule
`default_nettype wire

// File: hdl/mts_fifo.sv
`default_nettype none
module mts_fifo
	import mts_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mts_cmd_t wr_data,
	input  wire logic     wr_valid,
	output logic          wr_ready,
	output mts_cmd_t      rd_data,
	output logic          rd_valid,
	input  wire logic     rd_ready
);

	localparam int PW = $clog2(QDEPTH);
	localparam int FW = $clog2(QDEPTH + 1);

	mts_cmd_t      mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FW-1:0] fill_q;
	logic          push, pop;

	assign wr_ready = (fill_q != FW'(QDEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop)
				fill_q <= fill_q + FW'(1);
			else if (pop && !push)
				fill_q <= fill_q - FW'(1);
		end
	end

endmodule
`default_nettype wire

// File: hdl/mts_back.sv
`default_nettype none
module mts_back
	import mts_pkg::*;
#(
	parameter int MAX_NAME = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mts_cmd_t cmd,
	input  wire logic     cmd_valid,
	output logic          cmd_ready,
	output mts_out_t      result,
	output logic          result_valid,
	input  wire logic     result_ready
);

	localparam int DEPTH = MAX_NAME + 5;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int IW    = $clog2(DEPTH);

	typedef enum logic [2:0] {
		B_IDLE,
		B_REL1,
		B_ACT,
		B_PRE,
		B_REL2,
		B_MARK
	} state_t;

	state_t        state_q;
	mts_cmd_t      cmd_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] rd_q, rd_nxt;
	logic          emitted_q;
	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	mts_out_t      res_q, em;
	logic          res_valid_q;

	logic out_free, emit, rd_end, wr_en, marker;

	assign result       = res_q;
	assign result_valid = res_valid_q;
	assign cmd_ready    = (state_q == B_IDLE);
	assign out_free     = !res_valid_q || result_ready;
	assign rd_end       = (CW'(rd_q) + CW'(1)) == cnt_q;
	assign wr_en        = (state_q == B_ACT) && (cmd_q.act == ACT_HOLD) && (cnt_q < CW'(DEPTH));
	assign marker       = cmd_q.last && !cmd_q.rel_after && !emitted_q;

	always_comb begin
		emit   = 1'b0;
		em     = '0;
		rd_nxt = '0;
		unique case (state_q)
			B_REL1, B_REL2: begin
				emit            = out_free;
				em.out_byte     = rdata_q;
				em.out_has_byte = 1'b1;
				if (state_q == B_REL2)
					em.out_last = cmd_q.last && rd_end;
				else
					em.out_last = cmd_q.last && rd_end && (cmd_q.act != ACT_EMIT)
						&& !cmd_q.rel_after;
				if (!out_free)
					rd_nxt = rd_q;
				else if (!rd_end)
					rd_nxt = rd_q + IW'(1);
			end
			B_ACT: begin
				if (cmd_q.act == ACT_EMIT) begin
					emit            = out_free;
					em.out_byte     = cmd_q.data;
					em.out_has_byte = 1'b1;
					em.out_last     = cmd_q.last;
				end
			end
			B_MARK: begin
				emit        = out_free;
				em.out_last = 1'b1;
			end
			default: ;
		endcase
	end

	// held candidate bytes, registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[cnt_q[IW-1:0]] <= cmd_q.data;
		rdata_q <= mem[rd_nxt];
	end

	always_ff @(posedge clk) begin
		if (emit)
			res_q <= em;
		if (state_q == B_IDLE && cmd_valid)
			cmd_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			rd_q        <= '0;
			emitted_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_q <= rd_nxt;
			if (emit)
				res_valid_q <= 1'b1;
			else if (result_ready)
				res_valid_q <= 1'b0;

			unique case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						emitted_q <= 1'b0;
						state_q   <= (cmd.rel_first && cnt_q != '0) ? B_REL1 : B_ACT;
					end
				end
				B_REL1: begin
					if (emit) begin
						emitted_q <= 1'b1;
						if (rd_end) begin
							cnt_q   <= '0;
							state_q <= B_ACT;
						end
					end
				end
				B_ACT: begin
					unique case (cmd_q.act)
						ACT_EMIT: begin
							if (emit)
								state_q <= B_IDLE;
						end
						ACT_HOLD: begin
							if (wr_en)
								cnt_q <= cnt_q + CW'(1);
							if (cmd_q.rel_after)
								state_q <= B_PRE;
							else
								state_q <= marker ? B_MARK : B_IDLE;
						end
						ACT_DISCARD: begin
							cnt_q   <= '0;
							state_q <= marker ? B_MARK : B_IDLE;
						end
						default: begin
							state_q <= marker ? B_MARK : B_IDLE;
						end
					endcase
				end
				B_PRE: begin
					state_q <= B_REL2;
				end
				B_REL2: begin
					if (emit && rd_end) begin
						cnt_q   <= '0;
						state_q <= B_IDLE;
					end
				end
				B_MARK: begin
					if (emit)
						state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/markup_tag_stripper_top.sv
// A plain text beat passes through the command queue, then the back end's
// command and result registers, before it shows on result. The back end takes
// a new command only when idle; held bytes are read out through a single port.
// A two-entry command queue lets input run ahead while a flush is in progress.
// Reset (arst_n low, asynchronous) clears all control state; buffer contents stay.
`default_nettype none
module markup_tag_stripper_top
	import mts_pkg::*;
#(
	parameter int MAX_NAME = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mts_in_t  item,
	input  wire logic     item_valid,
	output logic          item_ready,
	output mts_out_t      result,
	output logic          result_valid,
	input  wire logic     result_ready
);

	mts_cmd_t f_cmd, q_cmd;
	logic     f_valid, f_ready, q_valid, q_ready;

	mts_front #(.MAX_NAME(MAX_NAME)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.cmd        (f_cmd),
		.cmd_valid  (f_valid),
		.cmd_ready  (f_ready)
	);

	mts_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (f_cmd),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_data  (q_cmd),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	mts_back #(.MAX_NAME(MAX_NAME)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (q_cmd),
		.cmd_valid    (q_valid),
		.cmd_ready    (q_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule
`default_nettype wire

// File: hdl/mts_checker.sv
`default_nettype none
module mts_checker
	import mts_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire mts_in_t  item,
	input wire logic     item_valid,
	input wire logic     item_ready,
	input wire mts_out_t result,
	input wire logic     result_valid,
	input wire logic     result_ready
);

	logic unused;
	assign unused = ^{item, item_valid, item_ready};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.out_has_byte |-> result.out_last)
		else $error("bare marker without last");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.out_has_byte |-> result.out_byte == 8'h00)
		else $error("bare marker with nonzero byte");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid)
		else $error("result valid right after reset");

endmodule

bind markup_tag_stripper_top mts_checker u_mts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item         (item),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result       (result),
	.result_valid (result_valid),
	.result_ready (result_ready)
);
`default_nettype wire
